[rtl/tte_pkg.sv]
package tte_pkg;

  localparam logic [15:0] EVT_SYN = 16'd0;
  localparam logic [15:0] EVT_KEY = 16'd1;
  localparam logic [15:0] EVT_ABS = 16'd3;

  localparam logic [15:0] CODE_SYN_REPORT = 16'h0000;
  localparam logic [15:0] CODE_SLOT       = 16'h002f;
  localparam logic [15:0] CODE_MAJOR      = 16'h0030;
  localparam logic [15:0] CODE_POS_X      = 16'h0035;
  localparam logic [15:0] CODE_POS_Y      = 16'h0036;
  localparam logic [15:0] CODE_TID        = 16'h0039;
  localparam logic [15:0] CODE_BTN_TOUCH  = 16'h014a;
  localparam logic [15:0] CODE_F7         = 16'd65;
  localparam logic [15:0] CODE_F8         = 16'd66;

  localparam logic [16:0] VAL_LIFTED      = 17'h1ffff;
  localparam logic [16:0] VAL_MAJOR       = 17'd6;
  localparam logic [10:0] PERMILLE_MAX    = 11'd1000;

  // floor(p / 1000) == (p * RECIP_1000) >> RECIP_SHIFT for p < 2**26
  localparam logic [26:0] RECIP_1000  = 27'd68719477;
  localparam int          RECIP_SHIFT = 36;

  localparam int CTL_MAP   = 0;
  localparam int CTL_LEFT  = 1;
  localparam int CTL_RIGHT = 2;
  localparam int CTL_LAND  = 3;
  localparam int PT_VALID  = 22;

  localparam logic [2:0] REG_CONTROL     = 3'd0;
  localparam logic [2:0] REG_MAX_X       = 3'd1;
  localparam logic [2:0] REG_MAX_Y       = 3'd2;
  localparam logic [2:0] REG_LEFT_PORT   = 3'd3;
  localparam logic [2:0] REG_RIGHT_PORT  = 3'd4;
  localparam logic [2:0] REG_LEFT_LAND   = 3'd5;
  localparam logic [2:0] REG_RIGHT_LAND  = 3'd6;

  typedef struct packed {
    logic [3:0]  control;
    logic [15:0] max_x;
    logic [15:0] max_y;
    logic [22:0] left_port;
    logic [22:0] right_port;
    logic [22:0] left_land;
    logic [22:0] right_land;
  } cfg_t;

  typedef struct packed {
    logic        press;
    logic        slot;
    logic        btn;
    logic [16:0] tid;
    logic [25:0] px;
    logic [25:0] py;
  } cmd_t;

  typedef enum logic [2:0] {
    ST_SLOT,
    ST_TID,
    ST_X,
    ST_Y,
    ST_MAJOR,
    ST_BTN,
    ST_SYN
  } step_t;

endpackage

[rtl/trigger_to_touch_event_mapper.sv]
// Channel   Handshake                        Payload
// in        in_valid / in_ready              in_side, in_event_type, in_key_code, in_key_value
// out       out_valid / out_ready            out_ev_type, out_ev_code, out_ev_value, out_last
// cfg       cfg_psel/penable/pwrite/pready   cfg_paddr, cfg_pwdata, cfg_prdata
//
// One output event per cycle unless out_ready stalls it: a press gives 6 or 7 events,
// a release 3 or 4, in the order set by the event sequencer in the back end.
// The front end classifies a request combinationally and takes one per cycle while
// its two-entry command queue has room. Reset is synchronous, active low.
// A stalled output holds the sequencer; the queue keeps the front end going.
module trigger_to_touch_event_mapper #(
  parameter int ID_WIDTH = 16
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic               in_side,
  input  logic [15:0]        in_event_type,
  input  logic [15:0]        in_key_code,
  input  logic signed [31:0] in_key_value,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [15:0]        out_ev_type,
  output logic [15:0]        out_ev_code,
  output logic signed [16:0] out_ev_value,
  output logic               out_last,
  input  logic               cfg_psel,
  input  logic               cfg_penable,
  input  logic               cfg_pwrite,
  input  logic [4:0]         cfg_paddr,
  input  logic [31:0]        cfg_pwdata,
  output logic [31:0]        cfg_prdata,
  output logic               cfg_pready
);

  tte_pkg::cfg_t cfg_r;
  logic [2:0]    reg_idx;
  logic          wr_en;

  logic          q_push, q_full, q_pop, q_valid;
  tte_pkg::cmd_t q_wdata, q_rdata;

  assign cfg_pready = 1'b1;
  assign reg_idx    = cfg_paddr[4:2];
  assign wr_en      = cfg_psel && cfg_penable && cfg_pwrite;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.control    <= 4'd6;
      cfg_r.max_x      <= 16'd1215;
      cfg_r.max_y      <= 16'd2687;
      cfg_r.left_port  <= 23'd0;
      cfg_r.right_port <= 23'd0;
      cfg_r.left_land  <= 23'd0;
      cfg_r.right_land <= 23'd0;
    end else if (wr_en) begin
      unique case (reg_idx)
        tte_pkg::REG_CONTROL:    cfg_r.control    <= cfg_pwdata[3:0];
        tte_pkg::REG_MAX_X:      cfg_r.max_x      <= cfg_pwdata[15:0];
        tte_pkg::REG_MAX_Y:      cfg_r.max_y      <= cfg_pwdata[15:0];
        tte_pkg::REG_LEFT_PORT:  cfg_r.left_port  <= cfg_pwdata[22:0];
        tte_pkg::REG_RIGHT_PORT: cfg_r.right_port <= cfg_pwdata[22:0];
        tte_pkg::REG_LEFT_LAND:  cfg_r.left_land  <= cfg_pwdata[22:0];
        tte_pkg::REG_RIGHT_LAND: cfg_r.right_land <= cfg_pwdata[22:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      tte_pkg::REG_CONTROL:    cfg_prdata = {28'd0, cfg_r.control};
      tte_pkg::REG_MAX_X:      cfg_prdata = {16'd0, cfg_r.max_x};
      tte_pkg::REG_MAX_Y:      cfg_prdata = {16'd0, cfg_r.max_y};
      tte_pkg::REG_LEFT_PORT:  cfg_prdata = {9'd0, cfg_r.left_port};
      tte_pkg::REG_RIGHT_PORT: cfg_prdata = {9'd0, cfg_r.right_port};
      tte_pkg::REG_LEFT_LAND:  cfg_prdata = {9'd0, cfg_r.left_land};
      tte_pkg::REG_RIGHT_LAND: cfg_prdata = {9'd0, cfg_r.right_land};
      default:                 cfg_prdata = 32'd0;
    endcase
  end

  tte_front #(
    .ID_WIDTH(ID_WIDTH)
  ) u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .side       (in_side),
    .event_type (in_event_type),
    .key_code   (in_key_code),
    .key_value  (in_key_value),
    .cfg        (cfg_r),
    .q_push     (q_push),
    .q_data     (q_wdata),
    .q_full     (q_full)
  );

  tte_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (q_push),
    .wr_data  (q_wdata),
    .full     (q_full),
    .pop      (q_pop),
    .rd_valid (q_valid),
    .rd_data  (q_rdata)
  );

  tte_back u_back (
    .clk          (clk),
    .rst_n        (rst_n),
    .q_valid      (q_valid),
    .q_data       (q_rdata),
    .q_pop        (q_pop),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .out_ev_type  (out_ev_type),
    .out_ev_code  (out_ev_code),
    .out_ev_value (out_ev_value),
    .out_last     (out_last)
  );

endmodule

[rtl/tte_front.sv]
module tte_front #(
  parameter int ID_WIDTH = 16
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  output logic            in_ready,
  input  logic            side,
  input  logic [15:0]     event_type,
  input  logic [15:0]     key_code,
  input  logic [31:0]     key_value,
  input  tte_pkg::cfg_t   cfg,
  output logic            q_push,
  output tte_pkg::cmd_t   q_data,
  input  logic            q_full
);

  logic [1:0]          held_r, held_nxt;
  logic [1:0]          cnt_r, cnt_nxt;
  logic [ID_WIDTH-1:0] tid_r, tid_nxt;

  logic                key_ok, do_press, do_rel;
  logic [22:0]         port_pt, land_pt, pt;
  logic [10:0]         raw_x, raw_y;
  logic [9:0]          mx, my;
  logic [1:0]          cnt_inc, cnt_dec;
  logic [ID_WIDTH+16:0] tid_ext;

  assign in_ready = !q_full;

  always_comb begin
    key_ok = (event_type == tte_pkg::EVT_KEY) &&
             (key_code == (side ? tte_pkg::CODE_F7 : tte_pkg::CODE_F8)) &&
             cfg.control[tte_pkg::CTL_MAP] &&
             (side ? cfg.control[tte_pkg::CTL_RIGHT] : cfg.control[tte_pkg::CTL_LEFT]);
    port_pt = side ? cfg.right_port : cfg.left_port;
    land_pt = side ? cfg.right_land : cfg.left_land;
    pt = (cfg.control[tte_pkg::CTL_LAND] && land_pt[tte_pkg::PT_VALID]) ? land_pt : port_pt;
    do_press = key_ok && (key_value == 32'd1) && !held_r[side] && pt[tte_pkg::PT_VALID];
    do_rel   = key_ok && (key_value == 32'd0) && held_r[side];

    raw_x = pt[10:0];
    raw_y = pt[21:11];
    mx = (raw_x > tte_pkg::PERMILLE_MAX) ? tte_pkg::PERMILLE_MAX[9:0] : raw_x[9:0];
    my = (raw_y > tte_pkg::PERMILLE_MAX) ? tte_pkg::PERMILLE_MAX[9:0] : raw_y[9:0];

    cnt_inc = (cnt_r == 2'd3) ? cnt_r : cnt_r + 2'd1;
    cnt_dec = (cnt_r == 2'd0) ? cnt_r : cnt_r - 2'd1;
    tid_ext = {17'd0, tid_r};

    q_data.press = do_press;
    q_data.slot  = side;
    q_data.btn   = do_press ? (cnt_r == 2'd0) : (cnt_dec == 2'd0);
    q_data.tid   = tid_ext[16:0];
    q_data.px    = {16'd0, mx} * {10'd0, cfg.max_x};
    q_data.py    = {16'd0, my} * {10'd0, cfg.max_y};

    q_push = in_valid && in_ready && (do_press || do_rel);

    held_nxt = held_r;
    cnt_nxt  = cnt_r;
    tid_nxt  = tid_r;
    if (q_push) begin
      held_nxt[side] = do_press;
      cnt_nxt = do_press ? cnt_inc : cnt_dec;
      if (do_press) begin
        tid_nxt = tid_r + {{(ID_WIDTH-1){1'b0}}, 1'b1};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      held_r <= 2'b00;
      cnt_r  <= 2'd0;
      tid_r  <= {{(ID_WIDTH-1){1'b0}}, 1'b1};
    end else begin
      held_r <= held_nxt;
      cnt_r  <= cnt_nxt;
      tid_r  <= tid_nxt;
    end
  end

endmodule

[rtl/tte_queue.sv]
module tte_queue (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          push,
  input  tte_pkg::cmd_t wr_data,
  output logic          full,
  input  logic          pop,
  output logic          rd_valid,
  output tte_pkg::cmd_t rd_data
);

  tte_pkg::cmd_t entry_r [2];
  logic          wr_ptr_r, wr_ptr_nxt;
  logic          rd_ptr_r, rd_ptr_nxt;
  logic [1:0]    count_r, count_nxt;

  assign full     = (count_r == 2'd2);
  assign rd_valid = (count_r != 2'd0);
  assign rd_data  = entry_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = push ? !wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt = pop ? !rd_ptr_r : rd_ptr_r;
    count_nxt  = count_r + {1'b0, push} - {1'b0, pop};
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entry_r[wr_ptr_r] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

endmodule

[rtl/tte_back.sv]
module tte_back (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               q_valid,
  input  tte_pkg::cmd_t      q_data,
  output logic               q_pop,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [15:0]        out_ev_type,
  output logic [15:0]        out_ev_code,
  output logic signed [16:0] out_ev_value,
  output logic               out_last
);

  tte_pkg::step_t step_r, step_nxt;
  logic           busy_r, busy_nxt;
  tte_pkg::cmd_t  cmd_r;
  logic           out_valid_r;
  logic [15:0]    type_r, code_r;
  logic [16:0]    value_r;
  logic           last_r;

  logic           adv;
  logic [25:0]    qsel;
  logic [52:0]    prod;
  logic [15:0]    quot;
  logic [15:0]    ev_type, ev_code;
  logic [16:0]    ev_value;

  assign out_valid    = out_valid_r;
  assign out_ev_type  = type_r;
  assign out_ev_code  = code_r;
  assign out_ev_value = value_r;
  assign out_last     = last_r;

  always_comb begin
    qsel = (step_r == tte_pkg::ST_X) ? cmd_r.px : cmd_r.py;
    prod = {27'd0, qsel} * {26'd0, tte_pkg::RECIP_1000};
    quot = prod[tte_pkg::RECIP_SHIFT +: 16];
  end

  always_comb begin
    adv   = busy_r && (!out_valid_r || out_ready);
    q_pop = q_valid && (!busy_r || (adv && step_r == tte_pkg::ST_SYN));
    step_nxt = step_r;
    busy_nxt = busy_r;
    ev_type  = tte_pkg::EVT_ABS;
    ev_code  = tte_pkg::CODE_SLOT;
    ev_value = {16'd0, cmd_r.slot};
    unique case (step_r)
      tte_pkg::ST_SLOT: begin
        step_nxt = tte_pkg::ST_TID;
      end
      tte_pkg::ST_TID: begin
        ev_code  = tte_pkg::CODE_TID;
        ev_value = cmd_r.press ? cmd_r.tid : tte_pkg::VAL_LIFTED;
        step_nxt = cmd_r.press ? tte_pkg::ST_X :
                   (cmd_r.btn ? tte_pkg::ST_BTN : tte_pkg::ST_SYN);
      end
      tte_pkg::ST_X: begin
        ev_code  = tte_pkg::CODE_POS_X;
        ev_value = {1'b0, quot};
        step_nxt = tte_pkg::ST_Y;
      end
      tte_pkg::ST_Y: begin
        ev_code  = tte_pkg::CODE_POS_Y;
        ev_value = {1'b0, quot};
        step_nxt = tte_pkg::ST_MAJOR;
      end
      tte_pkg::ST_MAJOR: begin
        ev_code  = tte_pkg::CODE_MAJOR;
        ev_value = tte_pkg::VAL_MAJOR;
        step_nxt = cmd_r.btn ? tte_pkg::ST_BTN : tte_pkg::ST_SYN;
      end
      tte_pkg::ST_BTN: begin
        ev_type  = tte_pkg::EVT_KEY;
        ev_code  = tte_pkg::CODE_BTN_TOUCH;
        ev_value = {16'd0, cmd_r.press};
        step_nxt = tte_pkg::ST_SYN;
      end
      tte_pkg::ST_SYN: begin
        ev_type  = tte_pkg::EVT_SYN;
        ev_code  = tte_pkg::CODE_SYN_REPORT;
        ev_value = 17'd0;
        step_nxt = tte_pkg::ST_SLOT;
      end
      default: begin
        step_nxt = tte_pkg::ST_SLOT;
      end
    endcase
    if (!adv) begin
      step_nxt = step_r;
    end
    if (adv && step_r == tte_pkg::ST_SYN) begin
      busy_nxt = 1'b0;
    end
    if (q_pop) begin
      busy_nxt = 1'b1;
      step_nxt = tte_pkg::ST_SLOT;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_r      <= tte_pkg::ST_SLOT;
      busy_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      step_r <= step_nxt;
      busy_r <= busy_nxt;
      if (adv) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      cmd_r <= q_data;
    end
    if (adv) begin
      type_r  <= ev_type;
      code_r  <= ev_code;
      value_r <= ev_value;
      last_r  <= (step_r == tte_pkg::ST_SYN);
    end
  end

endmodule

[dv/testbench.sv]
module testbench;
  import tte_pkg::*;

  typedef struct packed {
    logic        side;
    logic [15:0] etype;
    logic [15:0] code;
    logic [31:0] kval;
  } trigger_t;

  typedef struct packed {
    logic [15:0] ev_type;
    logic [15:0] ev_code;
    logic [16:0] ev_value;
    logic        last;
  } touch_ev_t;

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               in_valid = 1'b0;
  logic               in_ready;
  logic               in_side = 1'b0;
  logic [15:0]        in_event_type = '0;
  logic [15:0]        in_key_code = '0;
  logic signed [31:0] in_key_value = '0;
  logic               out_valid;
  logic               out_ready = 1'b0;
  logic [15:0]        out_ev_type;
  logic [15:0]        out_ev_code;
  logic signed [16:0] out_ev_value;
  logic               out_last;
  logic               cfg_psel = 1'b0;
  logic               cfg_penable = 1'b0;
  logic               cfg_pwrite = 1'b0;
  logic [4:0]         cfg_paddr = '0;
  logic [31:0]        cfg_pwdata = '0;
  logic [31:0]        cfg_prdata;
  logic               cfg_pready;

  trigger_to_touch_event_mapper i_dut (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .in_side      (in_side),
    .in_event_type(in_event_type),
    .in_key_code  (in_key_code),
    .in_key_value (in_key_value),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .out_ev_type  (out_ev_type),
    .out_ev_code  (out_ev_code),
    .out_ev_value (out_ev_value),
    .out_last     (out_last),
    .cfg_psel     (cfg_psel),
    .cfg_penable  (cfg_penable),
    .cfg_pwrite   (cfg_pwrite),
    .cfg_paddr    (cfg_paddr),
    .cfg_pwdata   (cfg_pwdata),
    .cfg_prdata   (cfg_prdata),
    .cfg_pready   (cfg_pready)
  );

  // shadow of the register file and mapper state
  logic [3:0]  ctl = 4'd6;
  logic [15:0] max_x = 16'd1215;
  logic [15:0] max_y = 16'd2687;
  logic [22:0] touch_pt [4] = '{default: '0}; // left port, right port, left land, right land
  logic        held [2] = '{default: 1'b0};
  int          active_cnt = 0;
  logic [15:0] next_tid = 16'd1;

  trigger_t  trigger_q [$];
  touch_ev_t expected_ev [$];
  trigger_t  req_next;
  touch_ev_t got_ev;
  touch_ev_t want_ev;

  int triggers_queued = 0;
  int triggers_accepted = 0;
  int events_checked = 0;
  int reg_writes = 0;
  int id_wraps = 0;
  int mismatches = 0;
  int src_idle_pct = 21;
  int sink_idle_pct = 21;
  bit long_stall_armed = 1'b0;
  bit long_stall_done = 1'b0;
  int stall_left = 0;

  initial begin
    forever #2 clk = ~clk;
  end

  initial begin
    #12000000;
    $display("timeout: %0d of %0d requests accepted, %0d events outstanding",
             triggers_accepted, triggers_queued, expected_ev.size());
    $display("FAIL trigger_to_touch_event_mapper");
    $finish;
  end

  task automatic flag_mismatch(input string msg);
    $display("ERROR: %s", msg);
    mismatches++;
  endtask

  task automatic emit(input logic [15:0] t, input logic [15:0] c, input logic [16:0] v,
                      input logic l);
    expected_ev.push_back('{t, c, v, l});
  endtask

  task automatic map_trigger(input logic side, input logic [15:0] etype,
                             input logic [15:0] code, input logic [31:0] kval);
    logic [22:0] pt;
    logic [10:0] mx;
    logic [10:0] my;
    if (etype != EVT_KEY) return;
    if (code != (side ? CODE_F7 : CODE_F8)) return;
    if (!ctl[CTL_MAP] || !ctl[side ? CTL_RIGHT : CTL_LEFT]) return;
    if (kval == 32'd1) begin
      if (held[side]) return;
      pt = touch_pt[side];
      if (ctl[CTL_LAND] && touch_pt[2 + side][PT_VALID]) pt = touch_pt[2 + side];
      if (!pt[PT_VALID]) return;
      mx = pt[10:0];
      my = pt[21:11];
      if (mx > PERMILLE_MAX) mx = PERMILLE_MAX;
      if (my > PERMILLE_MAX) my = PERMILLE_MAX;
      emit(EVT_ABS, CODE_SLOT, {16'd0, side}, 1'b0);
      emit(EVT_ABS, CODE_TID, {1'b0, next_tid}, 1'b0);
      next_tid = next_tid + 16'd1;
      if (next_tid == 16'd0) id_wraps++;
      emit(EVT_ABS, CODE_POS_X,
           17'(({16'd0, mx} * {11'd0, max_x}) / {16'd0, PERMILLE_MAX}), 1'b0);
      emit(EVT_ABS, CODE_POS_Y,
           17'(({16'd0, my} * {11'd0, max_y}) / {16'd0, PERMILLE_MAX}), 1'b0);
      emit(EVT_ABS, CODE_MAJOR, VAL_MAJOR, 1'b0);
      if (active_cnt == 0) emit(EVT_KEY, CODE_BTN_TOUCH, 17'd1, 1'b0);
      if (active_cnt < 3) active_cnt++;
      emit(EVT_SYN, CODE_SYN_REPORT, 17'd0, 1'b1);
      held[side] = 1'b1;
    end else if (kval == 32'd0) begin
      if (!held[side]) return;
      emit(EVT_ABS, CODE_SLOT, {16'd0, side}, 1'b0);
      emit(EVT_ABS, CODE_TID, VAL_LIFTED, 1'b0);
      if (active_cnt > 0) active_cnt--;
      if (active_cnt == 0) emit(EVT_KEY, CODE_BTN_TOUCH, 17'd0, 1'b0);
      emit(EVT_SYN, CODE_SYN_REPORT, 17'd0, 1'b1);
      held[side] = 1'b0;
    end
  endtask

  // request driver
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (!in_valid || in_ready) begin
      if (in_valid) begin
        map_trigger(in_side, in_event_type, in_key_code, in_key_value);
        triggers_accepted++;
      end
      if (trigger_q.size() != 0 && $urandom_range(99) >= src_idle_pct) begin
        req_next = trigger_q.pop_front();
        in_valid      <= 1'b1;
        in_side       <= req_next.side;
        in_event_type <= req_next.etype;
        in_key_code   <= req_next.code;
        in_key_value  <= req_next.kval;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // event monitor
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        got_ev = {out_ev_type, out_ev_code, out_ev_value, out_last};
        if (expected_ev.size() == 0) begin
          flag_mismatch($sformatf("unexpected event type %h code %h value %h last %b",
                                  got_ev.ev_type, got_ev.ev_code, got_ev.ev_value,
                                  got_ev.last));
        end else begin
          want_ev = expected_ev.pop_front();
          if (got_ev !== want_ev)
            flag_mismatch($sformatf("event %0d: got %h/%h/%h/%b want %h/%h/%h/%b",
                                    events_checked, got_ev.ev_type, got_ev.ev_code,
                                    got_ev.ev_value, got_ev.last, want_ev.ev_type,
                                    want_ev.ev_code, want_ev.ev_value, want_ev.last));
          events_checked++;
        end
      end
      if (long_stall_armed && !long_stall_done) begin
        stall_left = 150;
        long_stall_done = 1'b1;
      end
      if (stall_left != 0) begin
        stall_left--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= ($urandom_range(99) >= sink_idle_pct);
      end
    end
  end

  task automatic queue_trigger(input logic side, input logic [15:0] etype,
                               input logic [15:0] code, input logic [31:0] kval);
    trigger_q.push_back('{side, etype, code, kval});
    triggers_queued++;
  endtask

  task automatic key_down(input logic side);
    queue_trigger(side, EVT_KEY, side ? CODE_F7 : CODE_F8, 32'd1);
  endtask

  task automatic key_up(input logic side);
    queue_trigger(side, EVT_KEY, side ? CODE_F7 : CODE_F8, 32'd0);
  endtask

  task automatic random_trigger();
    int r;
    logic side;
    logic [15:0] code;
    r = $urandom_range(99);
    side = 1'($urandom_range(1));
    code = side ? CODE_F7 : CODE_F8;
    if (r < 75) begin
      if ($urandom_range(1)) key_down(side);
      else key_up(side);
    end else if (r < 83) begin
      queue_trigger(side, 16'($urandom), code, 32'($urandom_range(1)));
    end else if (r < 90) begin
      if ($urandom_range(1)) code = side ? CODE_F8 : CODE_F7;
      else code = 16'($urandom);
      queue_trigger(side, EVT_KEY, code, 32'($urandom_range(1)));
    end else if (r < 96) begin
      queue_trigger(side, EVT_KEY, code, $urandom);
    end else begin
      queue_trigger(side, 16'($urandom), 16'($urandom), $urandom);
    end
  endtask

  task automatic write_reg(input logic [2:0] idx, input logic [31:0] value);
    @(posedge clk);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b1;
    cfg_paddr   <= {idx, 2'b00};
    cfg_pwdata  <= value;
    @(posedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
    case (idx)
      REG_CONTROL:    ctl = value[3:0];
      REG_MAX_X:      max_x = value[15:0];
      REG_MAX_Y:      max_y = value[15:0];
      REG_LEFT_PORT:  touch_pt[0] = value[22:0];
      REG_RIGHT_PORT: touch_pt[1] = value[22:0];
      REG_LEFT_LAND:  touch_pt[2] = value[22:0];
      REG_RIGHT_LAND: touch_pt[3] = value[22:0];
      default: ;
    endcase
    reg_writes++;
  endtask

  function automatic logic [31:0] ctl_word(input bit map, input bit left, input bit right,
                                           input bit land);
    logic [31:0] w;
    w = '0;
    w[CTL_MAP] = map;
    w[CTL_LEFT] = left;
    w[CTL_RIGHT] = right;
    w[CTL_LAND] = land;
    return w;
  endfunction

  function automatic logic [31:0] point_word(input bit valid, input logic [10:0] x,
                                             input logic [10:0] y);
    logic [31:0] w;
    w = '0;
    w[10:0] = x;
    w[21:11] = y;
    w[PT_VALID] = valid;
    return w;
  endfunction

  function automatic logic [10:0] pick_permille();
    int r;
    r = $urandom_range(99);
    if (r < 10) return 11'd0;
    if (r < 25) return 11'($urandom_range(2047, 1000));
    return 11'($urandom_range(1000));
  endfunction

  function automatic logic [31:0] pick_panel_max();
    int r;
    r = $urandom_range(99);
    if (r < 10) return 32'd1;
    if (r < 20) return 32'd65535;
    return 32'($urandom_range(65535, 1));
  endfunction

  // mode 0 random, 1 largest panel and points, 2 smallest panel and points
  task automatic random_config(input int mode);
    logic [31:0] pt;
    int k;
    if ($urandom_range(99) < 70)
      write_reg(REG_CONTROL,
                ctl_word(1, 1, 1, 1'($urandom_range(1))) | ($urandom & 32'hffff_fff0));
    else
      write_reg(REG_CONTROL, $urandom);
    case (mode)
      1: begin
        write_reg(REG_MAX_X, 32'd65535);
        write_reg(REG_MAX_Y, 32'd65535);
      end
      2: begin
        write_reg(REG_MAX_X, 32'd1);
        write_reg(REG_MAX_Y, 32'd1);
      end
      default: begin
        write_reg(REG_MAX_X, pick_panel_max() | ($urandom & 32'hffff_0000));
        write_reg(REG_MAX_Y, pick_panel_max());
      end
    endcase
    for (k = 0; k < 4; k++) begin
      if (mode == 1) pt = 32'h007f_ffff;
      else if (mode == 2) pt = point_word(1, 11'd0, 11'd0);
      else pt = point_word($urandom_range(99) < 85, pick_permille(), pick_permille())
                | ($urandom & 32'hff80_0000);
      write_reg(3'(REG_LEFT_PORT + k), pt);
    end
  endtask

  // the front end may still be working on ignored requests, so allow some slack
  task automatic settle();
    while (triggers_accepted != triggers_queued) @(posedge clk);
    while (expected_ev.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  initial begin
    int i;
    int ph;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    // reset control has mapping off
    key_down(0);
    key_up(0);
    settle();

    write_reg(REG_CONTROL, ctl_word(1, 1, 1, 0));
    write_reg(REG_MAX_X, 32'd65535);
    write_reg(REG_MAX_Y, 32'd1);
    write_reg(REG_LEFT_PORT, point_word(1, 11'd1000, 11'd0));
    write_reg(REG_RIGHT_PORT, point_word(1, 11'd2047, 11'd2047));
    write_reg(REG_LEFT_LAND, 32'd0);
    write_reg(REG_RIGHT_LAND, point_word(1, 11'd0, 11'd500));
    queue_trigger(0, EVT_SYN, CODE_F8, 32'd1);
    queue_trigger(0, 16'hffff, CODE_F8, 32'd1);
    queue_trigger(0, EVT_KEY, CODE_F7, 32'd1);
    queue_trigger(1, EVT_KEY, CODE_F8, 32'd1);
    queue_trigger(1, EVT_KEY, 16'hffff, 32'd1);
    queue_trigger(0, EVT_KEY, 16'h0000, 32'd0);
    key_down(0);
    key_down(0);
    key_down(1);
    queue_trigger(0, EVT_KEY, CODE_F8, 32'd2);
    queue_trigger(0, EVT_KEY, CODE_F8, 32'hffff_ffff);
    queue_trigger(1, EVT_KEY, CODE_F7, 32'h8000_0000);
    queue_trigger(1, EVT_KEY, CODE_F7, 32'h7fff_ffff);
    key_up(1);
    key_up(0);
    key_up(0);
    settle();

    // landscape: left falls back to portrait, right uses its landscape point
    write_reg(REG_CONTROL, ctl_word(1, 1, 1, 1));
    key_down(0);
    key_down(1);
    settle();
    // right side disabled: held touch is kept, nothing emitted
    write_reg(REG_CONTROL, ctl_word(1, 1, 0, 1));
    key_up(1);
    key_down(1);
    settle();
    write_reg(REG_CONTROL, 32'd0);
    key_up(0);
    settle();
    write_reg(REG_CONTROL, 32'hf);
    key_up(0);
    key_up(1);
    settle();
    // no point positioned for the left side
    write_reg(REG_LEFT_PORT, 32'd0);
    key_down(0);
    key_down(1);
    key_up(1);
    settle();

    for (ph = 0; ph < 6; ph++) begin
      random_config(ph == 1 ? 1 : (ph == 3 ? 2 : 0));
      src_idle_pct = 21;
      sink_idle_pct = 21;
      if (ph == 2) begin
        src_idle_pct = 0;
        sink_idle_pct = 0;
      end
      if (ph == 4) begin
        src_idle_pct = 0;
        long_stall_armed = 1'b1;
      end
      for (i = 0; i < 72; i++) random_trigger();
      settle();
    end

    // back-to-back touches on both sides
    write_reg(REG_CONTROL, ctl_word(1, 1, 1, 0));
    write_reg(REG_LEFT_PORT, point_word(1, 11'd123, 11'd999));
    write_reg(REG_RIGHT_PORT, point_word(1, 11'd1000, 11'd1));
    src_idle_pct = 0;
    sink_idle_pct = 0;
    key_up(0);
    key_up(1);
    for (i = 0; i < 2; i++) begin
      key_down(0);
      key_down(1);
      key_up(0);
      key_up(1);
    end
    settle();

    $display("Ran %0d trigger requests, %0d touch events checked, %0d register writes.",
             triggers_accepted, events_checked, reg_writes);
    $display("Included a long output stall and %0d tracking id wrap(s).", id_wraps);
    if (mismatches == 0 && expected_ev.size() == 0) begin
      $display("PASS trigger_to_touch_event_mapper");
    end else begin
      $display("FAIL trigger_to_touch_event_mapper");
    end
    $finish;
  end

endmodule
